FILE: design/pghc_pkg.sv
// pghc_pkg: shared types and constants for the point grid hit counter.
// Used by the stream interface users, config registers, controller, datapath and top.
// No dependencies.
package pghc_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int COORD_W    = 24;
    localparam int COUNT_W    = 16;
    localparam int CELL_IDX_W = 18;
    localparam int DIV_STEPS  = 24;
    localparam int DIV_CNT_W  = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [15:0]        MIN_CELL_MM   = 16'd10;
    localparam logic [15:0]        MIN_THRESHOLD = 16'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd6;

    // reset values
    localparam logic [COORD_W-1:0] RST_ORIGIN    = 24'hFFB1E0;  // -20000
    localparam logic [15:0]        RST_CELL_SIZE = 16'd100;
    localparam logic [COORD_W-1:0] RST_Z_LOW     = 24'hFFFE70;  // -400
    localparam logic [COORD_W-1:0] RST_Z_HIGH    = 24'd2000;
    localparam logic [15:0]        RST_THRESHOLD = 16'd2;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    typedef enum logic [2:0] {
        RES_COUNTED   = 3'd0,
        RES_DISABLED  = 3'd1,
        RES_Z_BAND    = 3'd2,
        RES_OFF_GRID  = 3'd3,
        RES_READ_DONE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_CLASS,
        S_DIV,
        S_RANGE,
        S_MEMRD,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  opcode;
        logic [COORD_W-1:0]    point_x;
        logic [COORD_W-1:0]    point_y;
        logic [COORD_W-1:0]    point_z;
        logic [CELL_IDX_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [CELL_IDX_W-1:0] cell_address;
        logic [COUNT_W-1:0]    hit_count;
        logic                  occupied;
    } t_out_item;

    // cell_size and threshold hold clamped values
    typedef struct packed {
        logic               enable;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [15:0]        cell_size;
        logic [COORD_W-1:0] z_low;
        logic [COORD_W-1:0] z_high;
        logic [15:0]        threshold;
    } t_cfg;

    typedef struct packed {
        logic    clear_en;
        logic    latch_in;
        logic    prep;
        logic    div_start;
        logic    div_step;
        logic    calc_addr;
        logic    mem_rd;
        logic    update;
        logic    drop;
        t_status drop_code;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic opcode;
        logic read_oob;
        logic z_out;
        logic div_done;
        logic grid_out;
        logic out_valid;
    } t_dp_stat;

endpackage

FILE: design/pghc_stream_if.sv
// pghc_stream_if: valid/ready stream channel carrying one payload beat.
// Payload type is set per instance; no other dependencies.
interface pghc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/pghc_cfg_regs.sv
// pghc_cfg_regs: configuration register file with write-time clamping.
// Depends on pghc_pkg.
module pghc_cfg_regs import pghc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b1;
            r_cfg.base_x    <= RST_ORIGIN;
            r_cfg.base_y    <= RST_ORIGIN;
            r_cfg.cell_size <= RST_CELL_SIZE;
            r_cfg.z_low     <= RST_Z_LOW;
            r_cfg.z_high    <= RST_Z_HIGH;
            r_cfg.threshold <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:    r_cfg.enable   <= i_cfg_data[0];
                CFG_ORIGIN_X:  r_cfg.base_x   <= i_cfg_data;
                CFG_ORIGIN_Y:  r_cfg.base_y   <= i_cfg_data;
                CFG_CELL_SIZE: begin
                    r_cfg.cell_size <= (i_cfg_data[15:0] < MIN_CELL_MM) ? MIN_CELL_MM
                                                                        : i_cfg_data[15:0];
                end
                CFG_Z_LOW:     r_cfg.z_low    <= i_cfg_data;
                CFG_Z_HIGH:    r_cfg.z_high   <= i_cfg_data;
                CFG_THRESHOLD: begin
                    r_cfg.threshold <= (i_cfg_data[15:0] == 16'd0) ? MIN_THRESHOLD
                                                                   : i_cfg_data[15:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/pghc_datapath.sv
// pghc_datapath: offset subtract, two-lane restoring divider, address calc,
// hit store RAM with read-modify-write, result and output registers.
// Depends on pghc_pkg; driven by pghc_ctrl commands.
module pghc_datapath import pghc_pkg::*; #(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_in_item  i_item,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int unsigned CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int COL_W  = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int ROW_W  = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    t_in_item                   r_item;
    logic signed [COORD_W:0]    r_dx;
    logic signed [COORD_W:0]    r_dy;
    logic                       r_z_out;
    logic                       r_read_oob;
    logic                       r_xfar;
    logic                       r_yfar;
    logic [COORD_W-1:0]         r_qx;
    logic [COORD_W-1:0]         r_qy;
    logic [15:0]                r_rem_x;
    logic [15:0]                r_rem_y;
    logic [DIV_CNT_W-1:0]       r_div_cnt;
    logic [ADDR_W-1:0]          r_cell_addr;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic [COUNT_W-1:0]         r_mem [CELL_COUNT];
    logic [COUNT_W-1:0]         r_rd_data;
    t_status                    r_res_status;
    logic [ADDR_W-1:0]          r_res_addr;
    logic [COUNT_W-1:0]         r_res_count;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic [COORD_W+1:0] x_sum;
    logic [COORD_W+1:0] y_sum;
    logic [16:0]        x_shift;
    logic [16:0]        y_shift;
    logic [16:0]        divisor;
    logic               x_ge;
    logic               y_ge;
    logic [ADDR_W-1:0]  row_base;
    logic [COUNT_W-1:0] n_count;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;

    // small negative offsets truncate to index 0; x_sum <= 0 flags the rest
    assign x_sum   = {r_dx[COORD_W], r_dx} + (COORD_W+2)'(i_cfg.cell_size);
    assign y_sum   = {r_dy[COORD_W], r_dy} + (COORD_W+2)'(i_cfg.cell_size);
    assign divisor = {1'b0, i_cfg.cell_size};
    assign x_shift = {r_rem_x, r_qx[COORD_W-1]};
    assign y_shift = {r_rem_y, r_qy[COORD_W-1]};
    assign x_ge    = x_shift >= divisor;
    assign y_ge    = y_shift >= divisor;
    assign row_base = ADDR_W'(r_qy[ROW_W-1:0]) * ADDR_W'(GRID_WIDTH);
    assign n_count  = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 16'd1;

    assign mem_we    = i_cmd.clear_en || (i_cmd.update && r_item.opcode == OP_ACCUMULATE);
    assign mem_waddr = i_cmd.clear_en ? r_clr_addr : r_cell_addr;
    assign mem_wdata = i_cmd.clear_en ? '0 : n_count;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[r_cell_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_item <= i_item;
        end
        if (i_cmd.prep) begin
            r_dx <= $signed({r_item.point_x[COORD_W-1], r_item.point_x})
                  - $signed({i_cfg.base_x[COORD_W-1], i_cfg.base_x});
            r_dy <= $signed({r_item.point_y[COORD_W-1], r_item.point_y})
                  - $signed({i_cfg.base_y[COORD_W-1], i_cfg.base_y});
            r_z_out <= ($signed(r_item.point_z) < $signed(i_cfg.z_low))
                    || ($signed(r_item.point_z) > $signed(i_cfg.z_high));
            r_read_oob  <= 32'(r_item.cell_index) >= CELL_COUNT;
            r_cell_addr <= ADDR_W'(r_item.cell_index);
        end
        if (i_cmd.div_start) begin
            r_xfar    <= r_dx[COORD_W] && (x_sum[COORD_W+1] || x_sum == '0);
            r_yfar    <= r_dy[COORD_W] && (y_sum[COORD_W+1] || y_sum == '0);
            r_qx      <= r_dx[COORD_W] ? '0 : r_dx[COORD_W-1:0];
            r_qy      <= r_dy[COORD_W] ? '0 : r_dy[COORD_W-1:0];
            r_rem_x   <= '0;
            r_rem_y   <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            // one quotient bit per lane per cycle, dividend shifts out the top
            r_rem_x   <= x_ge ? 16'(x_shift - divisor) : x_shift[15:0];
            r_rem_y   <= y_ge ? 16'(y_shift - divisor) : y_shift[15:0];
            r_qx      <= {r_qx[COORD_W-2:0], x_ge};
            r_qy      <= {r_qy[COORD_W-2:0], y_ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.calc_addr) begin
            r_cell_addr <= row_base + ADDR_W'(r_qx[COL_W-1:0]);
        end
        if (i_cmd.drop) begin
            r_res_status <= i_cmd.drop_code;
            r_res_addr   <= '0;
            r_res_count  <= '0;
        end else if (i_cmd.update) begin
            r_res_status <= (r_item.opcode == OP_READ) ? RES_READ_DONE : RES_COUNTED;
            r_res_addr   <= r_cell_addr;
            r_res_count  <= (r_item.opcode == OP_READ) ? r_rd_data : n_count;
        end
        if (i_cmd.out_load) begin
            r_out.status       <= r_res_status;
            r_out.cell_address <= CELL_IDX_W'(r_res_addr);
            r_out.hit_count    <= r_res_count;
            r_out.occupied     <= (r_res_status == RES_COUNTED || r_res_status == RES_READ_DONE)
                                  && (r_res_count >= i_cfg.threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.clear_last = r_clr_addr == ADDR_W'(CELL_COUNT - 1);
        o_stat.opcode     = r_item.opcode;
        o_stat.read_oob   = r_read_oob;
        o_stat.z_out      = r_z_out;
        o_stat.div_done   = r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
        o_stat.grid_out   = r_xfar || r_yfar
                         || (r_qx >= COORD_W'(GRID_WIDTH))
                         || (r_qy >= COORD_W'(GRID_HEIGHT));
        o_stat.out_valid  = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: design/pghc_ctrl.sv
// pghc_ctrl: sequencing state machine for clear pass, accumulate and read.
// Depends on pghc_pkg; drives pghc_datapath through t_dp_cmd.
module pghc_ctrl import pghc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_enable,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_CLASS;
            end
            S_CLASS: begin
                if (i_stat.opcode == OP_READ) begin
                    if (i_stat.read_oob) begin
                        o_cmd.drop      = 1'b1;
                        o_cmd.drop_code = RES_OFF_GRID;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_MEMRD;
                    end
                end else if (!i_enable) begin
                    o_cmd.drop      = 1'b1;
                    o_cmd.drop_code = RES_DISABLED;
                    n_state         = S_DONE;
                end else if (i_stat.z_out) begin
                    o_cmd.drop      = 1'b1;
                    o_cmd.drop_code = RES_Z_BAND;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                if (i_stat.grid_out) begin
                    o_cmd.drop      = 1'b1;
                    o_cmd.drop_code = RES_OFF_GRID;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.calc_addr = 1'b1;
                    n_state         = S_MEMRD;
                end
            end
            S_MEMRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // output slot frees when the waiting beat is taken this cycle
                if (!i_stat.out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_stat.clear_last) |=> r_state == S_IDLE)
        else $error("clear pass did not end at last address");

    a_rd_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPDATE |-> $past(r_state) == S_MEMRD)
        else $error("update without a registered read the cycle before");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_stat.div_done) |=> r_state == S_DIV)
        else $error("divider left before its last step");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_stat.out_valid && !i_out_ready) |=> r_state == S_DONE)
        else $error("result overwrote a beat still waiting at the output");

endmodule

FILE: design/point_grid_hit_counter.sv
// point_grid_hit_counter: top level, bins 3D points into a 2D grid of hit counters.
// Depends on pghc_pkg, pghc_stream_if, pghc_cfg_regs, pghc_ctrl, pghc_datapath.
//
// After reset the block sweeps the hit store to zero, one counter per cycle, over all
// GRID_WIDTH*GRID_HEIGHT cells; i_in.ready stays low during that pass while
// configuration writes are taken as usual. Items are then handled one at a time.
// An accumulate beat that reaches the grid passes prep, classify, divide, range check,
// memory read and update, and the next beat can be taken once its result is loaded.
// Most of that path is the 24-step restoring divider that produces the column and row
// quotients side by side, one quotient bit per cycle. Beats dropped for mode or z
// band end after classify, points off the grid after the range check; reads skip the
// divider and do one registered read of the hit store, and accumulates then write back
// the saturating count. A finished result sits in an output register, so the next beat
// is accepted while it waits.
module point_grid_hit_counter import pghc_pkg::*; #(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pghc_stream_if.sink           i_in,
    pghc_stream_if.source         o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    pghc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pghc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (cfg.enable),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pghc_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_in.payload),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.payload)
    );

endmodule
